// ===== rtl/pva_pkg.sv =====
// Shared widths, codes, types and state encoding of the voice allocator.
`default_nettype none

package pva_pkg;

   localparam int OP_W    = 3;
   localparam int SND_W   = 16;
   localparam int OWN_W   = 16;
   localparam int SLOT_W  = 8;
   localparam int PRI_W   = 16;
   localparam int CNT_W   = 7;
   localparam int VIDX_W  = 6;
   localparam int MASK_W  = 64;
   localparam int CODE_W  = 2;

   localparam int DEF_MAX_VOICES = 64;
   localparam logic [CNT_W-1:0] NUM_VOICES_RST = 7'd16;

   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
   localparam logic [OP_W-1:0] OP_STOP_OWNER = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE    = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

   localparam logic [CODE_W-1:0] REJ_NONE     = 2'd0;
   localparam logic [CODE_W-1:0] REJ_SINGULAR = 2'd1;
   localparam logic [CODE_W-1:0] REJ_LIMIT    = 2'd2;
   localparam logic [CODE_W-1:0] REJ_NO_VOICE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SND_W-1:0]  sound_num;
      logic [OWN_W-1:0]  owner_id;
      logic [SLOT_W-1:0] owner_slot;
      logic [PRI_W-1:0]  req_priority;
      logic [CNT_W-1:0]  max_instances;
      logic              singular;
      logic [VIDX_W-1:0] voice_sel;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [VIDX_W-1:0] voice_index;
      logic [MASK_W-1:0] stopped_mask;
      logic [CODE_W-1:0] reject_code;
      logic              playing;
   } res_type;

   typedef struct packed {
      logic [SND_W-1:0]  sound;
      logic [OWN_W-1:0]  owner;
      logic [SLOT_W-1:0] slot;
      logic [PRI_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic             occ;
      logic             snd_eq;
      logic             own_eq;
      logic             slot_eq;
      logic             pri_ge;
      logic [PRI_W-1:0] pri;
   } cmp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LIMIT,
      ST_LIMIT_END,
      ST_OWNER,
      ST_ROTOR,
      ST_STEAL,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } st_type;

endpackage

`default_nettype wire

// ===== rtl/pva_req_if.sv =====
// Request channel: valid, ready and the request word fields.
`default_nettype none

interface pva_req_if import pva_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SND_W-1:0]  sound_num;
   logic [OWN_W-1:0]  owner_id;
   logic [SLOT_W-1:0] owner_slot;
   logic [PRI_W-1:0]  req_priority;
   logic [CNT_W-1:0]  max_instances;
   logic              singular;
   logic [VIDX_W-1:0] voice_sel;

   modport source (output valid, op, sound_num, owner_id, owner_slot, req_priority,
                   max_instances, singular, voice_sel, input ready);
   modport sink (input valid, op, sound_num, owner_id, owner_slot, req_priority,
                 max_instances, singular, voice_sel, output ready);
endinterface

`default_nettype wire

// ===== rtl/pva_rsp_if.sv =====
// Response channel: valid, ready and the result word fields.
`default_nettype none

interface pva_rsp_if import pva_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              granted;
   logic [VIDX_W-1:0] voice_index;
   logic [MASK_W-1:0] stopped_mask;
   logic [CODE_W-1:0] reject_code;
   logic              playing;

   modport source (output valid, granted, voice_index, stopped_mask, reject_code, playing,
                   input ready);
   modport sink (input valid, granted, voice_index, stopped_mask, reject_code, playing,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/pva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [AW-1:0]          raddr,
   output logic [WIDTH-1:0]       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/pva_cmp.sv =====
// Shared compare unit: matches one read voice entry against the request.
`default_nettype none

module pva_cmp import pva_pkg::*; (
   input  entry_type entry,
   input  logic      occ,
   input  logic      written,
   input  req_type   req,
   output cmp_type   m
);
   logic [SLOT_W-1:0] slot_eff;
   logic [PRI_W-1:0]  pri_eff;

   // A voice never written reads as all zero; a free voice has no sound or owner.
   assign slot_eff  = written ? entry.slot : '0;
   assign pri_eff   = written ? entry.prio : '0;

   assign m.occ     = occ;
   assign m.snd_eq  = occ && (entry.sound == req.sound_num);
   assign m.own_eq  = occ && (entry.owner == req.owner_id);
   assign m.slot_eq = (slot_eff == req.owner_slot);
   assign m.pri     = pri_eff;
   assign m.pri_ge  = (req.req_priority >= pri_eff);

endmodule

`default_nettype wire

// ===== rtl/pva_seq.sv =====
// Sequencer: scans the voice table through one RAM read port and the compare unit.
`default_nettype none

module pva_seq import pva_pkg::*; #(
   parameter int MAX_VOICES = DEF_MAX_VOICES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req,
   input  logic [CNT_W-1:0] n,
   input  logic             out_free,
   output sts_type          sts,
   output res_type          res
);
   localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

   st_type                  state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]        pipe_idx_ff, pipe_idx_in;
   logic [CNT_W-1:0]        found_ff, found_in;
   logic                    low_vld_ff, low_vld_in;
   logic [IDX_W-1:0]        low_idx_ff, low_idx_in;
   logic [PRI_W-1:0]        best_ff, best_in;
   logic                    free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        sel_idx_ff, sel_idx_in;
   logic [IDX_W-1:0]        rotor_ff, rotor_in;
   logic [MAX_VOICES-1:0]   occ_ff, occ_in;
   logic [MAX_VOICES-1:0]   wr_ff, wr_in;
   res_type                 res_ff, res_in;

   logic                    ram_we;
   entry_type               ram_wdata;
   entry_type               ram_rdata;
   cmp_type                 m;
   logic [MAX_VOICES-1:0]   nmask;
   logic [CNT_W-1:0]        addr_p1;
   logic [CNT_W-1:0]        rot_p1;
   logic [IDX_W-1:0]        addr_nx;
   logic [IDX_W-1:0]        rot_nx;
   logic [IDX_W-1:0]        rel_idx;
   logic                    scan_end;
   logic                    own_chk;
   logic                    lim_hit;
   logic                    own_hit;
   logic                    steal_hit;
   logic                    stop_hit;
   logic                    query_hit;

   pva_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_VOICES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (sel_idx_ff),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   pva_cmp u_cmp (
      .entry   (ram_rdata),
      .occ     (occ_ff[pipe_idx_ff]),
      .written (wr_ff[pipe_idx_ff]),
      .req     (req_ff),
      .m       (m)
   );

   always_comb begin
      for (int i = 0; i < MAX_VOICES; i++) begin
         nmask[i] = (CNT_W'(i) < n);
      end
   end

   assign addr_p1   = CNT_W'(addr_ff) + CNT_W'(1);
   assign rot_p1    = CNT_W'(rotor_ff) + CNT_W'(1);
   assign addr_nx   = (addr_p1 >= n) ? '0 : addr_p1[IDX_W-1:0];
   assign rot_nx    = (rot_p1 >= n) ? '0 : rot_p1[IDX_W-1:0];
   assign rel_idx   = req_ff.voice_sel[IDX_W-1:0];
   assign scan_end  = (cnt_ff >= n) && !pipe_vld_ff;
   assign own_chk   = (req_ff.owner_id != '0) && (req_ff.owner_slot != '0);
   assign lim_hit   = pipe_vld_ff && m.snd_eq;
   assign own_hit   = pipe_vld_ff && own_chk && m.own_eq && m.slot_eq;
   assign steal_hit = pipe_vld_ff && m.pri_ge;
   assign stop_hit  = pipe_vld_ff && m.own_eq && ((req_ff.owner_slot == '0) || m.slot_eq);
   assign query_hit = pipe_vld_ff && (req_ff.op == OP_QUERY) && m.snd_eq && m.own_eq;

   assign ram_wdata.sound = req_ff.sound_num;
   assign ram_wdata.owner = req_ff.owner_id;
   assign ram_wdata.slot  = req_ff.owner_slot;
   assign ram_wdata.prio  = req_ff.req_priority;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (req_ff.op)
               OP_ALLOC: begin
                  if (req_ff.sound_num == '0) begin
                     state_in = ST_DONE;
                  end else if (req_ff.max_instances != '0) begin
                     state_in = ST_LIMIT;
                  end else begin
                     state_in = ST_OWNER;
                  end
               end
               OP_STOP_OWNER: state_in = ST_SCAN;
               OP_QUERY:      state_in = ST_SCAN;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_LIMIT: begin
            if (lim_hit && req_ff.singular) begin
               state_in = ST_DONE;
            end else if (scan_end) begin
               state_in = ST_LIMIT_END;
            end
         end
         ST_LIMIT_END: begin
            if ((found_ff >= req_ff.max_instances) && !low_vld_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OWNER;
            end
         end
         ST_OWNER: begin
            if (own_hit) begin
               state_in = ST_WRITE;
            end else if (scan_end) begin
               state_in = free_vld_ff ? ST_WRITE : ST_ROTOR;
            end
         end
         ST_ROTOR: state_in = ST_STEAL;
         ST_STEAL: begin
            if (steal_hit) begin
               state_in = ST_WRITE;
            end else if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (query_hit || scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and table updates.
   always_comb begin
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = addr_ff;
      found_in    = found_ff;
      low_vld_in  = low_vld_ff;
      low_idx_in  = low_idx_ff;
      best_in     = best_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      sel_idx_in  = sel_idx_ff;
      rotor_in    = rotor_ff;
      occ_in      = occ_ff;
      wr_in       = wr_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;

      // Every scan state issues one read per cycle until n reads are out.
      if ((state_ff == ST_LIMIT) || (state_ff == ST_OWNER) ||
          (state_ff == ST_STEAL) || (state_ff == ST_SCAN)) begin
         if (cnt_ff < n) begin
            pipe_vld_in = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
            addr_in     = addr_nx;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
            end
         end
         ST_DISPATCH: begin
            res_in      = '0;
            cnt_in      = '0;
            addr_in     = '0;
            found_in    = '0;
            low_vld_in  = 1'b0;
            best_in     = req_ff.req_priority;
            free_vld_in = 1'b0;
            case (req_ff.op)
               OP_ALLOC: begin
                  if (req_ff.sound_num == '0) begin
                     res_in.reject_code = REJ_NO_VOICE;
                  end
               end
               OP_RELEASE: begin
                  if ((CNT_W'(req_ff.voice_sel) < n) && occ_ff[rel_idx]) begin
                     occ_in[rel_idx] = 1'b0;
                     res_in.stopped_mask[req_ff.voice_sel] = 1'b1;
                  end
               end
               OP_STOP_ALL: begin
                  res_in.stopped_mask = MASK_W'(occ_ff & nmask);
                  occ_in              = occ_ff & ~nmask;
               end
               default: begin
               end
            endcase
         end
         ST_LIMIT: begin
            if (lim_hit) begin
               if (req_ff.singular) begin
                  res_in.reject_code = REJ_SINGULAR;
               end else begin
                  found_in = found_ff + CNT_W'(1);
                  if (best_ff >= m.pri) begin
                     low_vld_in = 1'b1;
                     low_idx_in = pipe_idx_ff;
                     best_in    = m.pri;
                  end
               end
            end
         end
         ST_LIMIT_END: begin
            cnt_in  = '0;
            addr_in = '0;
            if (found_ff >= req_ff.max_instances) begin
               if (low_vld_ff) begin
                  occ_in[low_idx_ff] = 1'b0;
                  res_in.stopped_mask[VIDX_W'(low_idx_ff)] = 1'b1;
               end else begin
                  res_in.reject_code = REJ_LIMIT;
               end
            end
         end
         ST_OWNER: begin
            if (own_hit) begin
               occ_in[pipe_idx_ff] = 1'b0;
               res_in.stopped_mask[VIDX_W'(pipe_idx_ff)] = 1'b1;
               sel_idx_in = pipe_idx_ff;
            end else if (pipe_vld_ff && !m.occ && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = pipe_idx_ff;
            end
            if (scan_end && free_vld_ff) begin
               sel_idx_in = free_idx_ff;
            end
         end
         ST_ROTOR: begin
            rotor_in = rot_nx;
            addr_in  = rot_nx;
            cnt_in   = '0;
         end
         ST_STEAL: begin
            if (steal_hit) begin
               if (m.occ) begin
                  res_in.stopped_mask[VIDX_W'(pipe_idx_ff)] = 1'b1;
               end
               occ_in[pipe_idx_ff] = 1'b0;
               sel_idx_in = pipe_idx_ff;
            end else if (scan_end) begin
               res_in.reject_code = REJ_NO_VOICE;
            end
         end
         ST_SCAN: begin
            if (req_ff.op == OP_QUERY) begin
               if (query_hit) begin
                  res_in.playing = 1'b1;
               end
            end else if (stop_hit) begin
               occ_in[pipe_idx_ff] = 1'b0;
               res_in.stopped_mask[VIDX_W'(pipe_idx_ff)] = 1'b1;
            end
         end
         ST_WRITE: begin
            ram_we             = 1'b1;
            occ_in[sel_idx_ff] = 1'b1;
            wr_in[sel_idx_ff]  = 1'b1;
            res_in.granted     = 1'b1;
            res_in.voice_index = VIDX_W'(sel_idx_ff);
            res_in.reject_code = REJ_NONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pipe_vld_ff <= 1'b0;
         rotor_ff    <= '0;
         occ_ff      <= '0;
         wr_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         rotor_ff    <= rotor_in;
         occ_ff      <= occ_in;
         wr_ff       <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      pipe_idx_ff <= pipe_idx_in;
      found_ff    <= found_in;
      low_vld_ff  <= low_vld_in;
      low_idx_ff  <= low_idx_in;
      best_ff     <= best_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      sel_idx_ff  <= sel_idx_in;
      res_ff      <= res_in;
   end

   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = (state_ff == ST_DONE);
   assign res      = res_ff;

endmodule

`default_nettype wire

// ===== rtl/priority_voice_allocator_core.sv =====
// Top level of the priority voice allocator: channels, register and output stage.
//
//   Channel   Direction  Handshake          Word
//   --------  ---------  -----------------  --------------------------------------
//   req_ch    in         valid / ready      op, sound, owner, slot, priority, limit
//   rsp_ch    out        valid / ready      granted, voice, stopped mask, reject, playing
//   csr_*     in         write enable only  num_voices (7 bits)
//
// Each word is worked through by one sequencer that reads the voice table one entry per
// cycle from a single RAM read port. An allocate takes up to three scans, stop by owner
// and query take at most one scan, and release, stop all and unknown ops need no scan.
// Reset clears the occupancy and written flags, the steal rotor and num_voices (to 16);
// the table itself needs no clearing pass, since unwritten voices read as zero.
// A finished result waits in the output register, so the next request word is taken while
// the previous response word is still stalled; that request then completes once the output
// register is free.
`default_nettype none

module priority_voice_allocator_core import pva_pkg::*; #(
   parameter int MAX_VOICES = DEF_MAX_VOICES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   pva_req_if.sink          req_ch,
   pva_rsp_if.source        rsp_ch
);

   logic [CNT_W-1:0] num_voices_ff, num_voices_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] n_eff;
   logic             start;
   logic             out_free;
   req_type          req;
   sts_type          sts;
   res_type          res;

   // Register values beyond the built voice count behave as the built count.
   assign n_eff = (num_voices_ff > CNT_W'(MAX_VOICES)) ? CNT_W'(MAX_VOICES) : num_voices_ff;

   assign req.op            = req_ch.op;
   assign req.sound_num     = req_ch.sound_num;
   assign req.owner_id      = req_ch.owner_id;
   assign req.owner_slot    = req_ch.owner_slot;
   assign req.req_priority  = req_ch.req_priority;
   assign req.max_instances = req_ch.max_instances;
   assign req.singular      = req_ch.singular;
   assign req.voice_sel     = req_ch.voice_sel;

   assign req_ch.ready = sts.idle;
   assign start        = req_ch.valid && sts.idle;

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   pva_seq #(
      .MAX_VOICES (MAX_VOICES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .n        (n_eff),
      .out_free (out_free),
      .sts      (sts),
      .res      (res)
   );

   always_comb begin
      num_voices_in = csr_we ? csr_wdata : num_voices_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (sts.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_voices_ff <= NUM_VOICES_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_voices_ff <= num_voices_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted      = rsp_data_ff.granted;
   assign rsp_ch.voice_index  = rsp_data_ff.voice_index;
   assign rsp_ch.stopped_mask = rsp_data_ff.stopped_mask;
   assign rsp_ch.reject_code  = rsp_data_ff.reject_code;
   assign rsp_ch.playing      = rsp_data_ff.playing;

endmodule

`default_nettype wire
